### rtl/core/nsj_pkg.sv
// Shared types and constants of the neighbor-set Jaccard engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package nsj_pkg;

   localparam int NODE_W        = 6;
   localparam int SHARED_W      = 7;
   localparam int SIM_W         = 17;
   localparam int DEF_MAX_NODES = 64;
   localparam int DEF_FRAC_BITS = 16;

   // adjacency bits counted per popcount step
   localparam int CHUNK = 8;
   localparam int POP_W = $clog2(CHUNK + 1);

   typedef enum logic [0:0] {
      CMD_INSERT = 1'b0,
      CMD_QUERY  = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      SEL_FIRST  = 1'b0,
      SEL_SECOND = 1'b1
   } node_sel_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_INS_WR_A,
      ST_INS_RD_B,
      ST_INS_WR_B,
      ST_Q_READ_B,
      ST_Q_CAP_B,
      ST_COUNT,
      ST_UNION,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic         load_req;
      logic         clear_wr;
      logic         rd_en;
      node_sel_type rd_sel;
      logic         ins_wr;
      node_sel_type wr_sel;
      logic         cap_a;
      logic         cap_b;
      logic         count_step;
      logic         calc_union;
      logic         div_start;
      logic         load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic is_query;
      logic ins_ok;
      logic clear_last;
      logic count_last;
      logic div_done;
   } dp_status_type;

   function automatic logic [POP_W-1:0] chunk_pop(input logic [CHUNK-1:0] vec);
      logic [POP_W-1:0] n;
      n = '0;
      for (int i = 0; i < CHUNK; i++) begin
         n = n + POP_W'(vec[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

### rtl/core/nsj_divider.sv
// Restoring divider, one quotient bit per cycle, for a numerator not above the denominator.
// Standalone; instantiated by nsj_datapath.
`default_nettype none

module nsj_divider #(
   parameter int NUM_W = 7,
   parameter int DEN_W = 8,
   parameter int QUO_W = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [QUO_W-1:0] quo
);

   localparam int REM_W  = DEN_W + 1;
   localparam int STEP_W = $clog2(QUO_W + 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [REM_W-1:0]  trial;
   logic              take;

   always_comb begin
      // first step yields the integer bit, later steps bring in a zero
      trial   = (step_ff == '0) ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
      take    = (trial >= den_ff);
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = REM_W'(num);
         den_in  = REM_W'(den);
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = take ? (trial - den_ff) : trial;
         quo_in  = {quo_ff[QUO_W-2:0], take};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done = !busy_ff;
   assign quo  = quo_ff;

   // ratio never exceeds one
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> (quo_ff <= (QUO_W'(1) << (QUO_W - 1))))
      else $error("divider quotient above one");

endmodule

`default_nettype wire

### rtl/core/nsj_datapath.sv
// Datapath: adjacency row memory, request and result registers, chunked popcount, divider.
// Depends on nsj_pkg and nsj_divider; driven by nsj_ctrl through dp_cmd_type.
`default_nettype none

module nsj_datapath #(
   parameter int MAX_NODES = nsj_pkg::DEF_MAX_NODES,
   parameter int FRAC_BITS = nsj_pkg::DEF_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire nsj_pkg::dp_cmd_type        cmd,
   output nsj_pkg::dp_status_type          status,
   input  wire logic                       req_command,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_first_node,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_second_node,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_keystone_node,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_one_low,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_one_high,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_two_low,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_two_high,
   output logic [nsj_pkg::SHARED_W-1:0]    rsp_shared_count,
   output logic [nsj_pkg::SIM_W-1:0]       rsp_similarity
);

   import nsj_pkg::*;

   localparam int ROW_W  = MAX_NODES;
   localparam int ADDR_W = $clog2(MAX_NODES);
   localparam int NCHUNK = (MAX_NODES + CHUNK - 1) / CHUNK;
   localparam int PAD_W  = NCHUNK * CHUNK;
   localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int UN_W   = CNT_W + 1;
   localparam int QUO_W  = FRAC_BITS + 1;

   function automatic logic [ROW_W-1:0] node_onehot(input logic [NODE_W-1:0] node);
      logic [ROW_W-1:0] oh;
      for (int i = 0; i < ROW_W; i++) begin
         oh[i] = (int'(node) == i);
      end
      return oh;
   endfunction

   logic [ROW_W-1:0] row_mem [MAX_NODES];
   logic [ROW_W-1:0] rd_data_ff;

   cmd_type          cmd_ff, cmd_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic [PAD_W-1:0] sh_a_ff, sh_a_in, sh_b_ff, sh_b_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in, cnt_s_ff, cnt_s_in;
   logic [CHK_W-1:0] chk_ff, chk_in;
   logic [CNT_W-1:0] shared_ff, shared_in;
   logic [UN_W-1:0]  union_ff, union_in;

   logic [NODE_W-1:0]   e1l_ff, e1l_in, e1h_ff, e1h_in, e2l_ff, e2l_in, e2h_ff, e2h_in;
   logic [SHARED_W-1:0] shc_ff, shc_in;
   logic [SIM_W-1:0]    sim_ff, sim_in;

   logic              in_a, in_b;
   logic [ROW_W-1:0]  oh_a, oh_b, set_a, set_b;
   logic [ADDR_W-1:0] addr_a, addr_b, rd_addr, wr_addr;
   logic              wr_en;
   logic [ROW_W-1:0]  wr_data;
   logic [CNT_W-1:0]  size_a, size_b, shared_v;
   logic              div_done;
   logic [QUO_W-1:0]  quo;

   // node decode: out-of-range nodes address row zero and contribute only themselves
   always_comb begin
      in_a    = (int'(a_ff) < MAX_NODES);
      in_b    = (int'(b_ff) < MAX_NODES);
      oh_a    = node_onehot(a_ff);
      oh_b    = node_onehot(b_ff);
      addr_a  = in_a ? ADDR_W'(a_ff) : '0;
      addr_b  = in_b ? ADDR_W'(b_ff) : '0;
      rd_addr = (cmd.rd_sel == SEL_FIRST) ? addr_a : addr_b;
      set_a   = in_a ? (rd_data_ff | oh_a) : '0;
      set_b   = in_b ? (rd_data_ff | oh_b) : '0;
      wr_en   = cmd.clear_wr | cmd.ins_wr;
      if (cmd.clear_wr) begin
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.wr_sel == SEL_FIRST) begin
         wr_addr = addr_a;
         wr_data = rd_data_ff | oh_b;
      end else begin
         wr_addr = addr_b;
         wr_data = rd_data_ff | oh_a;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   always_comb begin
      cmd_in     = cmd_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      clr_cnt_in = clr_cnt_ff;
      if (cmd.load_req) begin
         cmd_in = cmd_type'(req_command);
         a_in   = req_first_node;
         b_in   = req_second_node;
         k_in   = req_keystone_node;
      end
      if (cmd.clear_wr) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
   end

   // popcount over the two loaded sets, one chunk a cycle
   always_comb begin
      sh_a_in  = sh_a_ff;
      sh_b_in  = sh_b_ff;
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      cnt_s_in = cnt_s_ff;
      chk_in   = chk_ff;
      if (cmd.cap_a) begin
         sh_a_in = PAD_W'(set_a);
      end
      if (cmd.cap_b) begin
         sh_b_in  = PAD_W'(set_b);
         cnt_a_in = '0;
         cnt_b_in = '0;
         cnt_s_in = '0;
         chk_in   = '0;
      end else if (cmd.count_step) begin
         sh_a_in  = sh_a_ff >> CHUNK;
         sh_b_in  = sh_b_ff >> CHUNK;
         cnt_a_in = cnt_a_ff + CNT_W'(chunk_pop(sh_a_ff[CHUNK-1:0]));
         cnt_b_in = cnt_b_ff + CNT_W'(chunk_pop(sh_b_ff[CHUNK-1:0]));
         cnt_s_in = cnt_s_ff + CNT_W'(chunk_pop(sh_a_ff[CHUNK-1:0] & sh_b_ff[CHUNK-1:0]));
         chk_in   = chk_ff + CHK_W'(1);
      end
   end

   always_comb begin
      size_a    = in_a ? cnt_a_ff : CNT_W'(1);
      size_b    = in_b ? cnt_b_ff : CNT_W'(1);
      shared_v  = (in_a && in_b) ? cnt_s_ff : CNT_W'(a_ff == b_ff);
      shared_in = shared_ff;
      union_in  = union_ff;
      if (cmd.calc_union) begin
         shared_in = shared_v;
         union_in  = UN_W'(size_a) + UN_W'(size_b) - UN_W'(shared_v);
      end
   end

   always_comb begin
      e1l_in = e1l_ff;
      e1h_in = e1h_ff;
      e2l_in = e2l_ff;
      e2h_in = e2h_ff;
      shc_in = shc_ff;
      sim_in = sim_ff;
      if (cmd.load_rsp) begin
         e1l_in = (k_ff < a_ff) ? k_ff : a_ff;
         e1h_in = (k_ff < a_ff) ? a_ff : k_ff;
         e2l_in = (k_ff < b_ff) ? k_ff : b_ff;
         e2h_in = (k_ff < b_ff) ? b_ff : k_ff;
         shc_in = SHARED_W'(shared_ff);
         sim_in = SIM_W'(quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
      cmd_ff    <= cmd_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      sh_a_ff   <= sh_a_in;
      sh_b_ff   <= sh_b_in;
      cnt_a_ff  <= cnt_a_in;
      cnt_b_ff  <= cnt_b_in;
      cnt_s_ff  <= cnt_s_in;
      chk_ff    <= chk_in;
      shared_ff <= shared_in;
      union_ff  <= union_in;
      e1l_ff    <= e1l_in;
      e1h_ff    <= e1h_in;
      e2l_ff    <= e2l_in;
      e2h_ff    <= e2h_in;
      shc_ff    <= shc_in;
      sim_ff    <= sim_in;
   end

   nsj_divider #(
      .NUM_W(CNT_W),
      .DEN_W(UN_W),
      .QUO_W(QUO_W)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(cmd.div_start),
      .num  (shared_ff),
      .den  (union_ff),
      .done (div_done),
      .quo  (quo)
   );

   assign status.is_query   = (cmd_ff == CMD_QUERY);
   assign status.ins_ok     = in_a && in_b;
   assign status.clear_last = (clr_cnt_ff == ADDR_W'(MAX_NODES - 1));
   assign status.count_last = (chk_ff == CHK_W'(NCHUNK - 1));
   assign status.div_done   = div_done;

   assign rsp_edge_one_low  = e1l_ff;
   assign rsp_edge_one_high = e1h_ff;
   assign rsp_edge_two_low  = e2l_ff;
   assign rsp_edge_two_high = e2h_ff;
   assign rsp_shared_count  = shc_ff;
   assign rsp_similarity    = sim_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.calc_union |=> (union_ff != '0))
      else $error("union count is zero");

   assert property (@(posedge clock) disable iff (reset)
      cmd.calc_union |=> (UN_W'(shared_ff) <= union_ff))
      else $error("shared count exceeds union count");

endmodule

`default_nettype wire

### rtl/core/nsj_ctrl.sv
// Controller state machine: request handshake, clearing pass, insert and query sequencing.
// Depends on nsj_pkg; commands nsj_datapath and owns the result valid flag.
`default_nettype none

module nsj_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output nsj_pkg::dp_cmd_type         cmd,
   input  wire nsj_pkg::dp_status_type status
);

   import nsj_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ_A;
            end
         end
         ST_READ_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_FIRST;
            if (status.is_query) begin
               state_in = ST_Q_READ_B;
            end else if (status.ins_ok) begin
               state_in = ST_INS_WR_A;
            end else begin
               // drop an insert with an out-of-range end
               state_in = ST_IDLE;
            end
         end
         ST_INS_WR_A: begin
            cmd.ins_wr = 1'b1;
            cmd.wr_sel = SEL_FIRST;
            state_in   = ST_INS_RD_B;
         end
         ST_INS_RD_B: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_SECOND;
            state_in   = ST_INS_WR_B;
         end
         ST_INS_WR_B: begin
            cmd.ins_wr = 1'b1;
            cmd.wr_sel = SEL_SECOND;
            state_in   = ST_IDLE;
         end
         ST_Q_READ_B: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = SEL_SECOND;
            cmd.cap_a  = 1'b1;
            state_in   = ST_Q_CAP_B;
         end
         ST_Q_CAP_B: begin
            cmd.cap_b = 1'b1;
            state_in  = ST_COUNT;
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (status.count_last) begin
               state_in = ST_UNION;
            end
         end
         ST_UNION: begin
            cmd.calc_union = 1'b1;
            state_in       = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free or being taken
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_rsp))
      else $error("result valid raised without a result load");

endmodule

`default_nettype wire

### rtl/core/neighbor_set_jaccard_engine.sv
// Top level of the neighbor-set Jaccard engine: controller plus datapath.
// Depends on nsj_pkg, nsj_ctrl, nsj_datapath (which holds nsj_divider).
//
//   Port group  Direction  Handshake             Payload
//   req_*       in         req_valid/req_stall   command, first, second, keystone node
//   rsp_*       out        rsp_valid/rsp_stall   two ordered edges, shared count, similarity
//
// After reset a clearing pass writes every adjacency row to zero; req_stall stays high
// throughout. An insert does a read-modify-write of its two rows, one after the other;
// an insert with an end out of range is dropped after the first row read.
// A query reads both rows and runs an 8-bit-per-cycle popcount of them, then
// the divider produces one quotient bit per divider cycle.
// The result sits in an output register; a stalled result only holds a finished query at its end.
`default_nettype none

module neighbor_set_jaccard_engine #(
   parameter int MAX_NODES = nsj_pkg::DEF_MAX_NODES,
   parameter int FRAC_BITS = nsj_pkg::DEF_FRAC_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_command,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_first_node,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_second_node,
   input  wire logic [nsj_pkg::NODE_W-1:0] req_keystone_node,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_one_low,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_one_high,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_two_low,
   output logic [nsj_pkg::NODE_W-1:0]      rsp_edge_two_high,
   output logic [nsj_pkg::SHARED_W-1:0]    rsp_shared_count,
   output logic [nsj_pkg::SIM_W-1:0]       rsp_similarity
);

   import nsj_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   nsj_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (dp_cmd),
      .status   (dp_status)
   );

   nsj_datapath #(
      .MAX_NODES(MAX_NODES),
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .status           (dp_status),
      .req_command      (req_command),
      .req_first_node   (req_first_node),
      .req_second_node  (req_second_node),
      .req_keystone_node(req_keystone_node),
      .rsp_edge_one_low (rsp_edge_one_low),
      .rsp_edge_one_high(rsp_edge_one_high),
      .rsp_edge_two_low (rsp_edge_two_low),
      .rsp_edge_two_high(rsp_edge_two_high),
      .rsp_shared_count (rsp_shared_count),
      .rsp_similarity   (rsp_similarity)
   );

endmodule

`default_nettype wire

### test/neighbor_set_jaccard_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for neighbor_set_jaccard_engine: edge inserts and edge-pair queries
// under several idle mixes, each response checked against a typed expectation or a local adjacency predictor.
// Depends on nsj_pkg and the engine RTL.
module neighbor_set_jaccard_engine_tb;
   import nsj_pkg::*;

   localparam int NODES           = DEF_MAX_NODES;
   localparam int FRAC            = DEF_FRAC_BITS;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int INSERT_TAIL     = 8;
   localparam int RANDOM_PER_MODE = 60;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 20;

   typedef struct packed {
      logic [NODE_W-1:0]   e1_lo;
      logic [NODE_W-1:0]   e1_hi;
      logic [NODE_W-1:0]   e2_lo;
      logic [NODE_W-1:0]   e2_hi;
      logic [SHARED_W-1:0] shared;
      logic [SIM_W-1:0]    sim;
   } jaccard_rsp_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [NODE_W-1:0] first;
      logic [NODE_W-1:0] second;
      logic [NODE_W-1:0] keystone;
      logic              typed;
      jaccard_rsp_type   want;
   } stim_row_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic              clock;
   logic              reset             = 1'b1;
   logic              req_valid         = 1'b0;
   logic              req_stall;
   cmd_type           req_command       = CMD_INSERT;
   logic [NODE_W-1:0] req_first_node    = '0;
   logic [NODE_W-1:0] req_second_node   = '0;
   logic [NODE_W-1:0] req_keystone_node = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [NODE_W-1:0]   rsp_edge_one_low;
   logic [NODE_W-1:0]   rsp_edge_one_high;
   logic [NODE_W-1:0]   rsp_edge_two_low;
   logic [NODE_W-1:0]   rsp_edge_two_high;
   logic [SHARED_W-1:0] rsp_shared_count;
   logic [SIM_W-1:0]    rsp_similarity;

   logic [NODES-1:0] graph_rows [NODES];
   jaccard_rsp_type  pending_results [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int mismatches         = 0;
   int results_checked    = 0;
   int inserts_sent       = 0;
   int queries_sent       = 0;
   int quiet_cycles       = 0;

   // expectations typed in where they follow at a glance: empty graph, equal nodes, extremes
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_QUERY,  6'd0,  6'd63, 6'd0,  1'b1, '{6'd0,  6'd0,  6'd0, 6'd63, 7'd0, 17'd0}},
      '{CMD_QUERY,  6'd5,  6'd5,  6'd63, 1'b1, '{6'd5,  6'd63, 6'd5, 6'd63, 7'd1, 17'd65536}},
      '{CMD_QUERY,  6'd63, 6'd0,  6'd63, 1'b1, '{6'd63, 6'd63, 6'd0, 6'd63, 7'd0, 17'd0}},
      '{CMD_INSERT, 6'd1,  6'd2,  6'd63, 1'b0, '0},
      '{CMD_INSERT, 6'd3,  6'd3,  6'd0,  1'b0, '0},
      '{CMD_QUERY,  6'd3,  6'd4,  6'd0,  1'b1, '{6'd0,  6'd3,  6'd0, 6'd4,  7'd0, 17'd0}},
      '{CMD_QUERY,  6'd1,  6'd2,  6'd0,  1'b1, '{6'd0,  6'd1,  6'd0, 6'd2,  7'd2, 17'd65536}},
      '{CMD_INSERT, 6'd1,  6'd3,  6'd42, 1'b0, '0},
      '{CMD_QUERY,  6'd2,  6'd3,  6'd1,  1'b0, '0},
      '{CMD_INSERT, 6'd0,  6'd63, 6'd21, 1'b0, '0},
      '{CMD_INSERT, 6'd63, 6'd62, 6'd0,  1'b0, '0},
      '{CMD_QUERY,  6'd0,  6'd62, 6'd63, 1'b0, '0},
      '{CMD_QUERY,  6'd62, 6'd0,  6'd63, 1'b0, '0},
      '{CMD_INSERT, 6'd63, 6'd0,  6'd63, 1'b0, '0},
      '{CMD_QUERY,  6'd63, 6'd63, 6'd0,  1'b1, '{6'd0,  6'd63, 6'd0, 6'd63, 7'd3, 17'd65536}},
      '{CMD_QUERY,  6'd42, 6'd21, 6'd42, 1'b0, '0},
      '{CMD_INSERT, 6'd42, 6'd21, 6'd0,  1'b0, '0},
      '{CMD_QUERY,  6'd42, 6'd21, 6'd0,  1'b0, '0},
      '{CMD_INSERT, 6'd0,  6'd1,  6'd7,  1'b0, '0},
      '{CMD_QUERY,  6'd1,  6'd63, 6'd0,  1'b0, '0}
   };

   neighbor_set_jaccard_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_first_node    (req_first_node),
      .req_second_node   (req_second_node),
      .req_keystone_node (req_keystone_node),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_edge_one_low  (rsp_edge_one_low),
      .rsp_edge_one_high (rsp_edge_one_high),
      .rsp_edge_two_low  (rsp_edge_two_low),
      .rsp_edge_two_high (rsp_edge_two_high),
      .rsp_shared_count  (rsp_shared_count),
      .rsp_similarity    (rsp_similarity)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned ones(input logic [NODES-1:0] v);
      int unsigned n;
      n = 0;
      for (int i = 0; i < NODES; i++) begin
         n += v[i];
      end
      return n;
   endfunction

   function automatic void record_edge(input logic [NODE_W-1:0] a, b);
      // every 6-bit node is in range at the default node count
      if (a < NODES && b < NODES) begin
         graph_rows[a][b] = 1'b1;
         graph_rows[b][a] = 1'b1;
      end
   endfunction

   // Jaccard ratio of the inclusive neighbor sets of a and b, plus the two ordered edges
   function automatic jaccard_rsp_type jaccard_of(input logic [NODE_W-1:0] a, b, k);
      logic [NODES-1:0] set_a;
      logic [NODES-1:0] set_b;
      int unsigned      shared;
      int unsigned      union_size;
      logic [63:0]      quotient;
      jaccard_rsp_type  r;
      set_a       = graph_rows[a];
      set_a[a]    = 1'b1;
      set_b       = graph_rows[b];
      set_b[b]    = 1'b1;
      shared      = ones(set_a & set_b);
      union_size  = ones(set_a) + ones(set_b) - shared;
      if (union_size == 0) begin
         union_size = 1;
      end
      quotient = (64'(shared) << FRAC) / union_size;
      r.e1_lo  = (k < a) ? k : a;
      r.e1_hi  = (k < a) ? a : k;
      r.e2_lo  = (k < b) ? k : b;
      r.e2_hi  = (k < b) ? b : k;
      r.shared = shared[SHARED_W-1:0];
      r.sim    = quotient[SIM_W-1:0];
      return r;
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            sender_idle_pct = 0;  receiver_stall_pct = 0;
         end
         IDLE_SENDER: begin
            sender_idle_pct = 88; receiver_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            sender_idle_pct = 0;  receiver_stall_pct = 88;
         end
         default: begin
            sender_idle_pct = 27; receiver_stall_pct = 27;
         end
      endcase
   endtask

   task automatic send_request(input cmd_type cmd, input logic [NODE_W-1:0] a, b, k,
                               input logic typed, input jaccard_rsp_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_first_node    <= a;
      req_second_node   <= b;
      req_keystone_node <= k;
      do @(posedge clock); while (req_stall);
      // accepted at this edge: advance the local graph or queue the expected response
      if (cmd == CMD_INSERT) begin
         record_edge(a, b);
         inserts_sent++;
      end else begin
         pending_results.push_back(typed ? want : jaccard_of(a, b, k));
         queries_sent++;
      end
   endtask

   // hold off until every response is back, plus the tail of a trailing insert
   task automatic wait_idle;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (INSERT_TAIL) @(posedge clock);
   endtask

   function automatic logic [NODE_W-1:0] near(input int base);
      return NODE_W'(base + $urandom_range(15));
   endfunction

   function automatic logic [NODE_W-1:0] neighbor_of(input logic [NODE_W-1:0] k,
                                                     input int base);
      logic [NODE_W-1:0] n;
      for (int t = 0; t < 16; t++) begin
         n = near(base);
         if (graph_rows[k][n] && n != k) begin
            return n;
         end
      end
      return near(base);
   endfunction

   // mostly edges and queries inside a 16-node community, the rest anywhere
   task automatic random_requests(input int count);
      int                base;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
      logic [NODE_W-1:0] k;
      base = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 25 == 0) begin
            base = $urandom_range(NODES - 16);
         end
         if ($urandom_range(99) < 45) begin
            if ($urandom_range(99) < 80) begin
               a = near(base);
               b = near(base);
            end else begin
               a = NODE_W'($urandom_range(NODES - 1));
               b = NODE_W'($urandom_range(NODES - 1));
            end
            send_request(CMD_INSERT, a, b, NODE_W'($urandom_range(NODES - 1)), 1'b0, '0);
         end else begin
            if ($urandom_range(99) < 85) begin
               k = near(base);
               a = neighbor_of(k, base);
               b = ($urandom_range(9) == 0) ? a : neighbor_of(k, base);
            end else begin
               k = NODE_W'($urandom_range(NODES - 1));
               a = NODE_W'($urandom_range(NODES - 1));
               b = NODE_W'($urandom_range(NODES - 1));
            end
            send_request(CMD_QUERY, a, b, k, 1'b0, '0);
         end
      end
   endtask

   // nodes 0 and 1 joined to every node: their sets both cover the whole graph
   task automatic hub_requests;
      for (int x = 0; x < NODES; x++) begin
         send_request(CMD_INSERT, 6'd0, NODE_W'(x), NODE_W'($urandom_range(NODES - 1)),
                      1'b0, '0);
         send_request(CMD_INSERT, NODE_W'(x), 6'd1, NODE_W'($urandom_range(NODES - 1)),
                      1'b0, '0);
      end
      for (int i = 0; i < 8; i++) begin
         send_request(CMD_QUERY, 6'd0, 6'd1, NODE_W'($urandom_range(NODES - 1)), 1'b0, '0);
         send_request(CMD_QUERY, NODE_W'($urandom_range(NODES - 1)), 6'd0, 6'd1, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic flag_field(input string field, input logic [31:0] want, got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("response %0d: %s expected %0d, got %0d", results_checked, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      jaccard_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("response %0d arrived with no query outstanding", results_checked);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_edge_one_low !== want.e1_lo)
               flag_field("edge_one_low", 32'(want.e1_lo), 32'(rsp_edge_one_low));
            if (rsp_edge_one_high !== want.e1_hi)
               flag_field("edge_one_high", 32'(want.e1_hi), 32'(rsp_edge_one_high));
            if (rsp_edge_two_low !== want.e2_lo)
               flag_field("edge_two_low", 32'(want.e2_lo), 32'(rsp_edge_two_low));
            if (rsp_edge_two_high !== want.e2_hi)
               flag_field("edge_two_high", 32'(want.e2_hi), 32'(rsp_edge_two_high));
            if (rsp_shared_count !== want.shared)
               flag_field("shared_count", 32'(want.shared), 32'(rsp_shared_count));
            if (rsp_similarity !== want.sim)
               flag_field("similarity", 32'(want.sim), 32'(rsp_similarity));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no request or response moved for %0d cycles", quiet_cycles);
         $display("neighbor_set_jaccard_engine_tb failed");
         $finish;
      end
   end

   initial begin
      foreach (graph_rows[i]) begin
         graph_rows[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_idle(IDLE_NONE);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].first, directed_rows[i].second,
                      directed_rows[i].keystone, directed_rows[i].typed,
                      directed_rows[i].want);
      end
      wait_idle;

      set_idle(IDLE_SENDER);
      random_requests(RANDOM_PER_MODE);
      wait_idle;
      set_idle(IDLE_RECEIVER);
      random_requests(RANDOM_PER_MODE);
      wait_idle;
      set_idle(IDLE_BOTH);
      hub_requests();
      random_requests(RANDOM_PER_MODE);
      set_idle(IDLE_NONE);
      random_requests(RANDOM_PER_MODE);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         mismatches += pending_results.size();
         $display("%0d expected responses never arrived", pending_results.size());
      end

      $display("covered %0d edge inserts and %0d pair queries over four idle mixes,",
               inserts_sent, queries_sent);
      $display("including a hub pair sharing every node; %0d responses checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("neighbor_set_jaccard_engine_tb passed");
      end else begin
         $display("neighbor_set_jaccard_engine_tb failed");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/nsj_pkg.sv
rtl/core/nsj_divider.sv
rtl/core/nsj_datapath.sv
rtl/core/nsj_ctrl.sv
rtl/core/neighbor_set_jaccard_engine.sv
test/neighbor_set_jaccard_engine_tb.sv
